### rtl/assert_macros.svh
// Assertion macros used by the top level of the gamepad decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, checked outside of reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

### rtl/gedk_pkg.sv
// Types, constants and helpers of the gamepad event key decoder.
`default_nettype none

package gedk_pkg;

  typedef logic [3:0] key_t;

  localparam key_t KEY_NONE   = 4'd0;
  localparam key_t KEY_UP     = 4'd1;
  localparam key_t KEY_DOWN   = 4'd2;
  localparam key_t KEY_LEFT   = 4'd3;
  localparam key_t KEY_RIGHT  = 4'd4;
  localparam key_t KEY_A      = 4'd5;
  localparam key_t KEY_B      = 4'd6;
  localparam key_t KEY_SELECT = 4'd7;
  localparam key_t KEY_START  = 4'd8;

  localparam logic [6:0] EVT_BUTTON = 7'd1;
  localparam logic [6:0] EVT_AXIS   = 7'd2;

  localparam logic [7:0] BTN_B_NUM      = 8'd0;
  localparam logic [7:0] BTN_A_NUM      = 8'd1;
  localparam logic [7:0] BTN_SELECT_NUM = 8'd8;
  localparam logic [7:0] BTN_START_NUM  = 8'd9;
  localparam logic [7:0] AXIS_X_NUM     = 8'd0;
  localparam logic [7:0] AXIS_Y_NUM     = 8'd1;

  localparam logic signed [15:0] AXIS_LOW  = -16'sd1024;
  localparam logic signed [15:0] AXIS_HIGH = 16'sd1024;

  localparam int SEQ_LEN_W  = 5;
  localparam int CFG_DATA_W = 64;
  localparam int MAX_SEQ    = 16;

  typedef enum logic {
    CFG_SEQ_LENGTH = 1'b0,
    CFG_SEQ_CODES  = 1'b1
  } cfg_index_e;

  typedef enum logic [2:0] {
    OP_IGNORE_SLOT,
    OP_CLEAR,
    OP_NOKEY,
    OP_BUTTON_PRESS,
    OP_BUTTON_RELEASE,
    OP_AXIS_NEG,
    OP_AXIS_POS,
    OP_AXIS_REL
  } op_kind_e;

  // Classified word passed from the front to the back. For buttons the key
  // sits in neg_key; for axes neg_key and pos_key name the two directions.
  typedef struct packed {
    op_kind_e   kind;
    logic [1:0] slot;
    key_t       neg_key;
    key_t       pos_key;
  } op_t;

  function automatic logic [7:0] key_bit(key_t code);
    return 8'd1 << 3'(code - 4'd1);
  endfunction

endpackage

`default_nettype wire

### rtl/gedk_if.sv
// Valid/ready channel interfaces for event words and result words.
`default_nettype none

interface gedk_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [1:0]         slot;
  logic [7:0]         event_type;
  logic [7:0]         event_number;
  logic signed [15:0] event_value;

  modport source (output valid, cmd, slot, event_type, event_number, event_value,
                  input ready);
  modport sink (input valid, cmd, slot, event_type, event_number, event_value,
                output ready);
endinterface

interface gedk_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] slot_out;
  logic [7:0] held_keys;
  logic [3:0] last_key;
  logic       last_pressed;
  logic       sequence_match;

  modport source (output valid, slot_out, held_keys, last_key, last_pressed,
                  sequence_match, input ready);
  modport sink (input valid, slot_out, held_keys, last_key, last_pressed,
                sequence_match, output ready);
endinterface

`default_nettype wire

### rtl/gedk_front.sv
// Front end: takes event words and classifies them into decoder operations.
`default_nettype none

module gedk_front #(
  parameter int SlotCount = 4
) (
  gedk_in_if.sink        in_ch,
  output logic           enq_valid_o,
  output gedk_pkg::op_t  enq_op_o,
  input  logic           enq_ready_i
);
  import gedk_pkg::*;

  op_t op;

  assign enq_valid_o = in_ch.valid;
  assign in_ch.ready = enq_ready_i;
  assign enq_op_o    = op;

  always_comb begin
    op.kind    = OP_NOKEY;
    op.slot    = in_ch.slot;
    op.neg_key = KEY_NONE;
    op.pos_key = KEY_NONE;
    if (int'(in_ch.slot) >= SlotCount) begin
      op.kind = OP_IGNORE_SLOT;
    end else if (in_ch.cmd) begin
      op.kind = OP_CLEAR;
    end else if (in_ch.event_type[6:0] == EVT_BUTTON) begin
      case (in_ch.event_number)
        BTN_B_NUM:      op.neg_key = KEY_B;
        BTN_A_NUM:      op.neg_key = KEY_A;
        BTN_SELECT_NUM: op.neg_key = KEY_SELECT;
        BTN_START_NUM:  op.neg_key = KEY_START;
        default:        op.neg_key = KEY_NONE;
      endcase
      if (op.neg_key != KEY_NONE) begin
        op.kind = (in_ch.event_value != '0) ? OP_BUTTON_PRESS : OP_BUTTON_RELEASE;
      end
    end else if (in_ch.event_type[6:0] == EVT_AXIS &&
                 (in_ch.event_number == AXIS_X_NUM ||
                  in_ch.event_number == AXIS_Y_NUM)) begin
      op.neg_key = (in_ch.event_number == AXIS_X_NUM) ? KEY_LEFT : KEY_UP;
      op.pos_key = (in_ch.event_number == AXIS_X_NUM) ? KEY_RIGHT : KEY_DOWN;
      if (in_ch.event_value <= AXIS_LOW) begin
        op.kind = OP_AXIS_NEG;
      end else if (in_ch.event_value >= AXIS_HIGH) begin
        op.kind = OP_AXIS_POS;
      end else begin
        op.kind = OP_AXIS_REL;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/gedk_queue.sv
// Two-entry queue of classified operations between the front and the back.
`default_nettype none

module gedk_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           enq_valid_i,
  input  gedk_pkg::op_t  enq_op_i,
  output logic           enq_ready_o,
  output logic           deq_valid_o,
  output gedk_pkg::op_t  deq_op_o,
  input  logic           deq_ready_i
);
  import gedk_pkg::*;

  op_t        entries_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign enq_ready_o = (count_q != 2'd2);
  assign deq_valid_o = (count_q != 2'd0);
  assign deq_op_o    = entries_q[rd_ptr_q];
  assign push        = enq_valid_i && enq_ready_o;
  assign pop         = deq_valid_o && deq_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= enq_op_i;
    end
  end

endmodule

`default_nettype wire

### rtl/gedk_back.sv
// Back end: per-slot key state, press history, sequence match and result register.
`default_nettype none

module gedk_back #(
  parameter int SlotCount    = 4,
  parameter int HistoryDepth = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  gedk_pkg::cfg_index_e  cfg_index_i,
  input  logic [63:0]           cfg_wdata_i,
  input  logic                  deq_valid_i,
  input  gedk_pkg::op_t         deq_op_i,
  output logic                  deq_ready_o,
  gedk_out_if.source            out_ch
);
  import gedk_pkg::*;

  localparam int SlotIdxW = (SlotCount > 1) ? $clog2(SlotCount) : 1;
  localparam int HistW    = 4 * HistoryDepth;

  logic [7:0]           held_mask_q [SlotCount];
  logic [HistW-1:0]     hist_q      [SlotCount];
  logic [SEQ_LEN_W-1:0] seq_len_q;
  logic [63:0]          seq_codes_q;

  logic                 out_valid_q, out_valid_d;
  logic [1:0]           slot_q;
  logic [7:0]           held_q;
  key_t                 key_q;
  logic                 pressed_q;
  logic                 match_q;

  logic                 pop;
  logic                 slot_ok;
  logic [SlotIdxW-1:0]  idx;
  logic [7:0]           cur_mask, new_mask, nb, pb;
  logic [HistW-1:0]     cur_hist, new_hist;
  logic [63:0]          hist_ext;
  key_t                 new_key;
  logic                 new_pressed;
  logic                 new_match;
  logic [4:0]           hi;

  assign pop         = deq_valid_i && (!out_valid_q || out_ch.ready);
  assign deq_ready_o = !out_valid_q || out_ch.ready;
  assign slot_ok     = (deq_op_i.kind != OP_IGNORE_SLOT);
  assign idx         = SlotIdxW'(deq_op_i.slot);
  assign cur_mask    = slot_ok ? held_mask_q[idx] : 8'd0;
  assign cur_hist    = slot_ok ? hist_q[idx] : '0;
  assign nb          = key_bit(deq_op_i.neg_key);
  assign pb          = key_bit(deq_op_i.pos_key);

  // Apply the operation to the slot's mask and work out the reported key.
  always_comb begin
    new_mask    = cur_mask;
    new_key     = KEY_NONE;
    new_pressed = 1'b0;
    case (deq_op_i.kind)
      OP_IGNORE_SLOT: new_mask = 8'd0;
      OP_CLEAR:       new_mask = 8'd0;
      OP_NOKEY:       new_mask = cur_mask;
      OP_BUTTON_PRESS: begin
        new_key     = deq_op_i.neg_key;
        new_pressed = 1'b1;
        new_mask    = cur_mask | nb;
      end
      OP_BUTTON_RELEASE: begin
        new_key  = deq_op_i.neg_key;
        new_mask = cur_mask & ~nb;
      end
      OP_AXIS_NEG: begin
        new_key     = deq_op_i.neg_key;
        new_pressed = 1'b1;
        new_mask    = (cur_mask | nb) & ~pb;
      end
      OP_AXIS_POS: begin
        new_key     = deq_op_i.pos_key;
        new_pressed = 1'b1;
        new_mask    = (cur_mask | pb) & ~nb;
      end
      OP_AXIS_REL: begin
        // A release reports the direction that was held, the negative one first.
        if ((cur_mask & nb) != 8'd0) begin
          new_key = deq_op_i.neg_key;
        end else if ((cur_mask & pb) != 8'd0) begin
          new_key = deq_op_i.pos_key;
        end
        new_mask = cur_mask & ~(nb | pb);
      end
      default: new_mask = cur_mask;
    endcase
  end

  // Newest history entry sits in the low nibble; a press shifts it in.
  always_comb begin
    if (deq_op_i.kind == OP_CLEAR || deq_op_i.kind == OP_IGNORE_SLOT) begin
      new_hist = '0;
    end else if (new_pressed && new_key != KEY_NONE) begin
      new_hist = HistW'({cur_hist, new_key});
    end else begin
      new_hist = cur_hist;
    end
    hist_ext = 64'(new_hist);
  end

  // Sequence element si (oldest first) is compared against history entry len-1-si.
  always_comb begin
    hi        = 5'd0;
    new_match = (32'(seq_len_q) <= HistoryDepth) && slot_ok;
    for (int si = 0; si < MAX_SEQ; si++) begin
      if (5'(si) < seq_len_q) begin
        hi = seq_len_q - 5'd1 - 5'(si);
        if (hist_ext[{hi[3:0], 2'b00} +: 4] != seq_codes_q[4*si +: 4]) begin
          new_match = 1'b0;
        end
      end
    end
  end

  assign out_valid_d = pop || (out_valid_q && !out_ch.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SlotCount; i++) begin
        held_mask_q[i] <= 8'd0;
        hist_q[i]      <= '0;
      end
      seq_len_q   <= '0;
      seq_codes_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop && slot_ok) begin
        held_mask_q[idx] <= new_mask;
        hist_q[idx]      <= new_hist;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SEQ_LENGTH: seq_len_q   <= cfg_wdata_i[SEQ_LEN_W-1:0];
          CFG_SEQ_CODES:  seq_codes_q <= cfg_wdata_i;
          default:        seq_len_q   <= seq_len_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      slot_q    <= deq_op_i.slot;
      held_q    <= new_mask;
      key_q     <= new_key;
      pressed_q <= new_pressed;
      match_q   <= new_match;
    end
  end

  assign out_ch.valid          = out_valid_q;
  assign out_ch.slot_out       = slot_q;
  assign out_ch.held_keys      = held_q;
  assign out_ch.last_key       = key_q;
  assign out_ch.last_pressed   = pressed_q;
  assign out_ch.sequence_match = match_q;

endmodule

`default_nettype wire

### rtl/gamepad_event_key_decoder_unit.sv
// Top level of the gamepad event key decoder.
`default_nettype none

// Decodes joystick event words for SLOT_COUNT gamepad slots into a held-key
// mask, the key named by the event and a press flag, and reports whether the
// newest presses of the slot equal the configured key sequence. Every event
// word yields exactly one result word. The block takes one event word per
// clock cycle while the operation queue has room. A result word passes
// through the two-entry operation queue and then the result register
// before it is presented.
// Stalls on the result channel fill the queue before the input stalls.
// Configuration writes take effect on the next cycle.
`include "assert_macros.svh"

module gamepad_event_key_decoder_unit #(
  parameter int SLOT_COUNT    = 4,
  parameter int HISTORY_DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  gedk_pkg::cfg_index_e  cfg_index_i,
  input  logic [63:0]           cfg_wdata_i,
  gedk_in_if.sink               in_ch,
  gedk_out_if.source            out_ch
);
  import gedk_pkg::*;

  logic enq_valid, enq_ready;
  logic deq_valid, deq_ready;
  op_t  enq_op, deq_op;

  gedk_front #(
    .SlotCount (SLOT_COUNT)
  ) u_front (
    .in_ch       (in_ch),
    .enq_valid_o (enq_valid),
    .enq_op_o    (enq_op),
    .enq_ready_i (enq_ready)
  );

  gedk_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .enq_valid_i (enq_valid),
    .enq_op_i    (enq_op),
    .enq_ready_o (enq_ready),
    .deq_valid_o (deq_valid),
    .deq_op_o    (deq_op),
    .deq_ready_i (deq_ready)
  );

  gedk_back #(
    .SlotCount    (SLOT_COUNT),
    .HistoryDepth (HISTORY_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .deq_valid_i (deq_valid),
    .deq_op_i    (deq_op),
    .deq_ready_o (deq_ready),
    .out_ch      (out_ch)
  );

  // A word taken from the queue always lands in the result register.
  `ASSERT_NEXT(a_pop_gives_result, clk_i, rst_ni, deq_valid && deq_ready, out_ch.valid)

  // A slot outside the configured range reports an all-zero state.
  `ASSERT_NEXT(a_ignored_slot_zero, clk_i, rst_ni, deq_valid && deq_ready && deq_op.kind == OP_IGNORE_SLOT, out_ch.held_keys == 8'd0 && out_ch.last_key == KEY_NONE && !out_ch.sequence_match)

  // A press always names a key, and that key is then held.
  `ASSERT_IMPLIES(a_press_names_key, clk_i, rst_ni, out_ch.valid && out_ch.last_pressed, out_ch.last_key != KEY_NONE && (out_ch.held_keys & key_bit(out_ch.last_key)) != 8'd0)

endmodule

`default_nettype wire

### tb/sv/tb_gamepad_event_key_decoder_unit.sv
// Self-checking testbench of the gamepad event key decoder: directed and random event words.
module tb_gamepad_event_key_decoder_unit;
  import gedk_pkg::*;

  localparam logic CMD_EVENT = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;
  localparam logic [7:0] INIT_FLAG = 8'h80;
  localparam int SLOTS = 4;

  typedef struct {
    logic               cmd;
    logic [1:0]         slot;
    logic [7:0]         etype;
    logic [7:0]         enumber;
    logic signed [15:0] evalue;
  } gamepad_event_t;

  typedef struct {
    logic [1:0] slot_out;
    logic [7:0] held_keys;
    key_t       last_key;
    logic       last_pressed;
    logic       sequence_match;
  } key_report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  cfg_index_e  cfg_index_i;
  logic [63:0] cfg_wdata_i;

  gedk_in_if  in_ch ();
  gedk_out_if out_ch ();

  gamepad_event_key_decoder_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  always #10 clk_i = ~clk_i;

  // Mirror of the per-slot key state and of the sequence registers.
  logic [7:0]  held_mask [SLOTS];
  key_t        recent_key [SLOTS];
  logic        recent_pressed [SLOTS];
  logic [63:0] press_history [SLOTS];
  logic [4:0]  match_length;
  logic [63:0] match_codes;

  key_report_t expected_reports[$];
  int unsigned error_count = 0;
  int unsigned burst_left = 0;

  function automatic logic [7:0] key_flag(key_t k);
    return 8'd1 << (k - 4'd1);
  endfunction

  // The newest history entry sits in the low nibble; the sequence is stored oldest first.
  function automatic logic history_matches(logic [63:0] hist);
    if (match_length > 5'd16) return 1'b0;
    for (int i = 0; i < match_length; i++) begin
      if (hist[4*(match_length-1-i) +: 4] != match_codes[4*i +: 4]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void move_axis(int s, logic signed [15:0] v, key_t neg, key_t pos);
    logic [7:0] nb;
    logic [7:0] pb;
    nb = key_flag(neg);
    pb = key_flag(pos);
    if (v <= AXIS_LOW) begin
      recent_key[s] = neg;
      recent_pressed[s] = 1'b1;
      held_mask[s] = (held_mask[s] | nb) & ~pb;
    end else if (v >= AXIS_HIGH) begin
      recent_key[s] = pos;
      recent_pressed[s] = 1'b1;
      held_mask[s] = (held_mask[s] | pb) & ~nb;
    end else begin
      // A release names the direction that was held, if any.
      if (held_mask[s] & nb) recent_key[s] = neg;
      else if (held_mask[s] & pb) recent_key[s] = pos;
      else recent_key[s] = KEY_NONE;
      recent_pressed[s] = 1'b0;
      held_mask[s] = held_mask[s] & ~(nb | pb);
    end
  endfunction

  function automatic key_report_t decode_event(gamepad_event_t ev);
    key_report_t rep;
    logic [6:0] kind;
    key_t k;
    int s;
    s = ev.slot;
    kind = ev.etype[6:0];
    if (ev.cmd == CMD_CLEAR) begin
      held_mask[s] = '0;
      recent_key[s] = KEY_NONE;
      recent_pressed[s] = 1'b0;
      press_history[s] = '0;
    end else begin
      if (kind == EVT_BUTTON) begin
        case (ev.enumber)
          BTN_B_NUM:      k = KEY_B;
          BTN_A_NUM:      k = KEY_A;
          BTN_SELECT_NUM: k = KEY_SELECT;
          BTN_START_NUM:  k = KEY_START;
          default:        k = KEY_NONE;
        endcase
        recent_key[s] = k;
        recent_pressed[s] = (k != KEY_NONE) && (ev.evalue != 0);
        if (k != KEY_NONE) begin
          if (ev.evalue != 0) held_mask[s] = held_mask[s] | key_flag(k);
          else held_mask[s] = held_mask[s] & ~key_flag(k);
        end
      end else if (kind == EVT_AXIS && ev.enumber == AXIS_X_NUM) begin
        move_axis(s, ev.evalue, KEY_LEFT, KEY_RIGHT);
      end else if (kind == EVT_AXIS && ev.enumber == AXIS_Y_NUM) begin
        move_axis(s, ev.evalue, KEY_UP, KEY_DOWN);
      end else begin
        recent_key[s] = KEY_NONE;
        recent_pressed[s] = 1'b0;
      end
      if (recent_key[s] != KEY_NONE && recent_pressed[s])
        press_history[s] = {press_history[s][59:0], recent_key[s]};
    end
    rep.slot_out = ev.slot;
    rep.held_keys = held_mask[s];
    rep.last_key = recent_key[s];
    rep.last_pressed = recent_pressed[s];
    rep.sequence_match = history_matches(press_history[s]);
    return rep;
  endfunction

  function automatic gamepad_event_t make_event(logic cmd, logic [1:0] slot, logic [7:0] etype,
                                                logic [7:0] enumber, logic [15:0] evalue);
    gamepad_event_t ev;
    ev.cmd = cmd;
    ev.slot = slot;
    ev.etype = etype;
    ev.enumber = enumber;
    ev.evalue = evalue;
    return ev;
  endfunction

  function automatic gamepad_event_t press_event(key_t k, logic [1:0] slot);
    logic [15:0] neg_v;
    logic [15:0] pos_v;
    logic [15:0] btn_v;
    neg_v = 16'(-1024 - int'($urandom_range(0, 31744)));
    pos_v = 16'(1024 + int'($urandom_range(0, 31743)));
    btn_v = 16'($urandom_range(1, 65535));
    case (k)
      KEY_UP:     return make_event(CMD_EVENT, slot, {1'b0, EVT_AXIS}, AXIS_Y_NUM, neg_v);
      KEY_DOWN:   return make_event(CMD_EVENT, slot, {1'b0, EVT_AXIS}, AXIS_Y_NUM, pos_v);
      KEY_LEFT:   return make_event(CMD_EVENT, slot, {1'b0, EVT_AXIS}, AXIS_X_NUM, neg_v);
      KEY_RIGHT:  return make_event(CMD_EVENT, slot, {1'b0, EVT_AXIS}, AXIS_X_NUM, pos_v);
      KEY_A:      return make_event(CMD_EVENT, slot, {1'b0, EVT_BUTTON}, BTN_A_NUM, btn_v);
      KEY_B:      return make_event(CMD_EVENT, slot, {1'b0, EVT_BUTTON}, BTN_B_NUM, btn_v);
      KEY_SELECT: return make_event(CMD_EVENT, slot, {1'b0, EVT_BUTTON}, BTN_SELECT_NUM, btn_v);
      default:    return make_event(CMD_EVENT, slot, {1'b0, EVT_BUTTON}, BTN_START_NUM, btn_v);
    endcase
  endfunction

  // Mostly well-formed button and axis words, with clears and raw noise mixed in.
  function automatic gamepad_event_t random_event();
    gamepad_event_t ev;
    int pick;
    logic init_bit;
    pick = $urandom_range(0, 99);
    init_bit = ($urandom_range(0, 3) == 0);
    ev = make_event(CMD_EVENT, 2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                    16'($urandom));
    if (pick < 6) begin
      ev.cmd = CMD_CLEAR;
    end else if (pick < 56 && pick >= 16) begin
      ev.etype = {init_bit, EVT_BUTTON};
      case ($urandom_range(0, 4))
        0: ev.enumber = BTN_B_NUM;
        1: ev.enumber = BTN_A_NUM;
        2: ev.enumber = BTN_SELECT_NUM;
        3: ev.enumber = BTN_START_NUM;
        default: ;
      endcase
      if ($urandom_range(0, 1) == 0) ev.evalue = '0;
    end else if (pick >= 56) begin
      ev.etype = {init_bit, EVT_AXIS};
      if ($urandom_range(0, 9) != 0) ev.enumber = $urandom_range(0, 1) ? AXIS_Y_NUM : AXIS_X_NUM;
      case ($urandom_range(0, 3))
        0, 1: ev.evalue = 16'(int'($urandom_range(0, 2400)) - 1200);
        2: ev.evalue = '0;
        default: ;
      endcase
    end
    return ev;
  endfunction

  // Sends one word; the sender pauses between bursts of random length.
  task automatic send_event(gamepad_event_t ev);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= ev.cmd;
    in_ch.slot <= ev.slot;
    in_ch.event_type <= ev.etype;
    in_ch.event_number <= ev.enumber;
    in_ch.event_value <= ev.evalue;
    do @(posedge clk_i); while (!in_ch.ready);
    expected_reports.push_back(decode_event(ev));
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_reports.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_index_e idx, logic [63:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_SEQ_LENGTH) match_length = data[4:0];
    else match_codes = data;
  endtask

  task automatic play_sequence(logic [1:0] slot);
    for (int i = 0; i < match_length; i++) send_event(press_event(match_codes[4*i +: 4], slot));
  endtask

  function automatic logic sequence_playable();
    if (match_length == 0 || match_length > 5'd16) return 1'b0;
    for (int i = 0; i < match_length; i++) begin
      if (match_codes[4*i +: 4] == KEY_NONE || match_codes[4*i +: 4] > KEY_START) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [63:0] pressable_codes();
    logic [63:0] codes;
    for (int i = 0; i < 16; i++) codes[4*i +: 4] = 4'($urandom_range(1, 8));
    return codes;
  endfunction

  task automatic check_field(string name, int unsigned exp, int unsigned act);
    if (exp != act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    key_report_t exp;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_reports.size() == 0) begin
        $error("result word for slot %0d with nothing pending", out_ch.slot_out);
        error_count++;
      end else begin
        exp = expected_reports.pop_front();
        check_field("slot_out", exp.slot_out, out_ch.slot_out);
        check_field("held_keys", exp.held_keys, out_ch.held_keys);
        check_field("last_key", exp.last_key, out_ch.last_key);
        check_field("last_pressed", exp.last_pressed, out_ch.last_pressed);
        check_field("sequence_match", exp.sequence_match, out_ch.sequence_match);
      end
    end
  end

  // The receiver switches between always ready, coin flips and a fixed stall pattern.
  int unsigned ready_mode = 0;
  int unsigned ready_left = 0;
  int unsigned ready_tick = 0;

  initial out_ch.ready = 1'b0;

  always @(negedge clk_i) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 2);
      ready_left = $urandom_range(20, 80);
    end
    ready_left--;
    ready_tick++;
    case (ready_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= 1'($urandom_range(0, 1));
      default: out_ch.ready <= (ready_tick % 8) >= 3;
    endcase
  end

  task automatic test_buttons();
    send_event(make_event(CMD_EVENT, 2'd0, {1'b0, EVT_BUTTON}, BTN_B_NUM, 16'd1));
    send_event(make_event(CMD_EVENT, 2'd0, {1'b0, EVT_BUTTON}, BTN_A_NUM, 16'h8000));
    send_event(make_event(CMD_EVENT, 2'd0, INIT_FLAG | {1'b0, EVT_BUTTON}, BTN_SELECT_NUM,
                          16'h7fff));
    send_event(make_event(CMD_EVENT, 2'd0, {1'b0, EVT_BUTTON}, BTN_START_NUM, 16'hffff));
    send_event(make_event(CMD_EVENT, 2'd0, {1'b0, EVT_BUTTON}, BTN_A_NUM, 16'd0));
    // Unmapped buttons and unknown event types leave the mask alone.
    send_event(make_event(CMD_EVENT, 2'd0, {1'b0, EVT_BUTTON}, 8'd2, 16'd1));
    send_event(make_event(CMD_EVENT, 2'd0, {1'b0, EVT_BUTTON}, 8'hff, 16'd1));
    send_event(make_event(CMD_EVENT, 2'd0, 8'h00, BTN_B_NUM, 16'd1));
    send_event(make_event(CMD_EVENT, 2'd0, 8'hff, 8'h00, 16'h8000));
  endtask

  task automatic test_axes_and_clear();
    send_event(make_event(CMD_EVENT, 2'd1, {1'b0, EVT_AXIS}, AXIS_X_NUM, AXIS_LOW));
    send_event(make_event(CMD_EVENT, 2'd1, {1'b0, EVT_AXIS}, AXIS_X_NUM, AXIS_HIGH));
    send_event(make_event(CMD_EVENT, 2'd1, {1'b0, EVT_AXIS}, AXIS_X_NUM, 16'sd1023));
    send_event(make_event(CMD_EVENT, 2'd1, {1'b0, EVT_AXIS}, AXIS_X_NUM, -16'sd1023));
    send_event(make_event(CMD_EVENT, 2'd1, INIT_FLAG | {1'b0, EVT_AXIS}, AXIS_Y_NUM, 16'h8000));
    send_event(make_event(CMD_EVENT, 2'd1, {1'b0, EVT_AXIS}, AXIS_Y_NUM, 16'h7fff));
    send_event(make_event(CMD_EVENT, 2'd1, {1'b0, EVT_AXIS}, 8'd2, 16'h8000));
    send_event(make_event(CMD_EVENT, 2'd1, {1'b0, EVT_AXIS}, AXIS_Y_NUM, 16'd0));
    send_event(make_event(CMD_EVENT, 2'd1, {1'b0, EVT_AXIS}, AXIS_X_NUM, 16'h7fff));
    send_event(make_event(CMD_CLEAR, 2'd1, 8'hff, 8'hff, 16'hffff));
    send_event(make_event(CMD_CLEAR, 2'd3, 8'h00, 8'h00, 16'h0000));
  endtask

  task automatic test_sequence_match();
    drain();
    write_reg(CFG_SEQ_LENGTH, 64'd3);
    write_reg(CFG_SEQ_CODES, {52'd0, KEY_START, KEY_A, KEY_UP});
    send_event(press_event(KEY_UP, 2'd2));
    send_event(press_event(KEY_A, 2'd2));
    send_event(press_event(KEY_START, 2'd2));
    send_event(make_event(CMD_EVENT, 2'd2, {1'b0, EVT_BUTTON}, BTN_START_NUM, 16'd0));
    drain();
    write_reg(CFG_SEQ_LENGTH, 64'd1);
    write_reg(CFG_SEQ_CODES, {64{1'b1}});
    send_event(press_event(KEY_B, 2'd2));
  endtask

  task automatic run_random_phase(logic [4:0] len, logic [63:0] codes, int count);
    int sent;
    drain();
    write_reg(CFG_SEQ_LENGTH, 64'(len));
    write_reg(CFG_SEQ_CODES, codes);
    sent = 0;
    while (sent < count) begin
      if (sequence_playable() && $urandom_range(0, 9) == 0) begin
        play_sequence(2'($urandom_range(0, 3)));
        sent += match_length;
      end else begin
        send_event(random_event());
        sent++;
      end
    end
  endtask

  task automatic test_random();
    run_random_phase(5'd0, 64'd0, 150);
    run_random_phase(5'd4, pressable_codes(), 200);
    run_random_phase(5'd16, pressable_codes(), 200);
    run_random_phase(5'd17, {$urandom, $urandom}, 120);
    run_random_phase(5'd2, 64'd0, 150);
    run_random_phase(5'd31, {64{1'b1}}, 100);
    run_random_phase(5'd1, pressable_codes(), 130);
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_SEQ_LENGTH;
    cfg_wdata_i = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_EVENT;
    in_ch.slot = '0;
    in_ch.event_type = '0;
    in_ch.event_number = '0;
    in_ch.event_value = '0;
    for (int s = 0; s < SLOTS; s++) begin
      held_mask[s] = '0;
      recent_key[s] = KEY_NONE;
      recent_pressed[s] = 1'b0;
      press_history[s] = '0;
    end
    match_length = '0;
    match_codes = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_buttons();
    test_axes_and_clear();
    test_sequence_match();
    test_random();
    drain();

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("FAIL");
    $finish;
  end

endmodule

### gamepad_event_key_decoder_unit.f
+incdir+rtl
rtl/gedk_pkg.sv
rtl/gedk_if.sv
rtl/gedk_front.sv
rtl/gedk_queue.sv
rtl/gedk_back.sv
rtl/gamepad_event_key_decoder_unit.sv
tb/sv/tb_gamepad_event_key_decoder_unit.sv
